@@ rtl/core/drkt_pkg.sv @@
package drkt_pkg;

  localparam int unsigned TYPE_WIDTH  = 16;
  localparam int unsigned CODE_WIDTH  = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned SEC_WIDTH   = 32;
  localparam int unsigned USEC_WIDTH  = 20;
  localparam int unsigned TOUT_WIDTH  = 24;
  localparam int unsigned CFG_WIDTH   = 48;
  localparam int unsigned IDX_WIDTH   = 3;

  localparam logic [TYPE_WIDTH-1:0]  EV_KEY         = 16'd1;
  localparam logic [TYPE_WIDTH-1:0]  EV_MSC         = 16'd4;
  localparam logic [CODE_WIDTH-1:0]  MISC_SCAN_CODE = 16'd4;
  localparam logic [CODE_WIDTH-1:0]  SYNC_CODE      = 16'd0;
  localparam logic [VALUE_WIDTH-1:0] VAL_PRESS      = 32'd1;
  localparam logic [VALUE_WIDTH-1:0] VAL_REPEAT     = 32'd2;

  localparam logic [TOUT_WIDTH-1:0] DEFAULT_TIMEOUT = 24'd200000;
  localparam logic [CFG_WIDTH-1:0]  DEFAULT_SLOT0   = 48'h00000_02B002A;
  localparam int                    MICROS_PER_SEC  = 1000000;

  typedef logic [IDX_WIDTH-1:0] cfg_index_t;

  localparam cfg_index_t REG_TIMEOUT    = 3'd0;
  localparam cfg_index_t REG_SLOT_FIRST = 3'd1;
  localparam int unsigned SLOT_REGS     = 4;

  // power of two
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CODE_WIDTH-1:0] modifier;
    logic [CODE_WIDTH-1:0] tap;
  } tap_cmd_t;

  typedef enum logic [2:0] {
    STEP_MOD_DOWN,
    STEP_TAP_DOWN,
    STEP_TAP_UP,
    STEP_MOD_UP,
    STEP_SYNC
  } step_t;

endpackage

@@ rtl/core/drkt_event_if.sv @@
interface drkt_event_if;
  logic        valid;
  logic        ready;
  logic [15:0] event_type;
  logic [15:0] event_code;
  logic signed [31:0] event_value;
  logic [31:0] stamp_seconds;
  logic [19:0] stamp_micros;

  modport source (
    output valid, event_type, event_code, event_value, stamp_seconds, stamp_micros,
    input  ready
  );
  modport sink (
    input  valid, event_type, event_code, event_value, stamp_seconds, stamp_micros,
    output ready
  );
endinterface

@@ rtl/core/drkt_result_if.sv @@
interface drkt_result_if;
  logic        valid;
  logic        ready;
  logic        out_type;
  logic [15:0] out_code;
  logic        out_value;
  logic        last_of_run;

  modport source (
    output valid, out_type, out_code, out_value, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, out_type, out_code, out_value, last_of_run,
    output ready
  );
endinterface

@@ rtl/core/drkt_front.sv @@
module drkt_front #(
  parameter int unsigned BINDING_SLOTS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  drkt_pkg::cfg_index_t                cfg_index,
  input  logic [drkt_pkg::CFG_WIDTH-1:0]      cfg_data,
  drkt_event_if.sink                          evt,
  input  logic                                q_ready,
  output logic                                push,
  output drkt_pkg::tap_cmd_t                  push_cmd
);
  import drkt_pkg::*;

  logic [TOUT_WIDTH-1:0]  tap_timeout;
  logic [CFG_WIDTH-1:0]   slot [BINDING_SLOTS];

  logic                   armed;
  logic [VALUE_WIDTH-1:0] latest_scancode;
  logic [VALUE_WIDTH-1:0] pressed_scancode;
  logic [SEC_WIDTH-1:0]   press_seconds;
  logic [USEC_WIDTH-1:0]  press_micros;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] value;
  logic                   is_scan;
  logic                   key_act;
  logic                   is_press;
  logic signed [SEC_WIDTH:0]  dsec;
  logic signed [USEC_WIDTH+1:0] udiff;
  logic signed [USEC_WIDTH+2:0] elapsed;
  logic                   d_gt1;
  logic                   d_le_m2;
  logic                   in_time;
  logic                   hit;
  tap_cmd_t               hit_cmd;

  assign accept   = evt.valid && evt.ready;
  assign evt.ready = q_ready;
  assign value    = evt.event_value;
  assign is_scan  = (evt.event_type == EV_MSC) && (evt.event_code == MISC_SCAN_CODE);
  assign key_act  = (evt.event_type == EV_KEY) && armed && (value != VAL_REPEAT);
  assign is_press = (value == VAL_PRESS);

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_timeout <= DEFAULT_TIMEOUT;
    end else if (cfg_write && cfg_index == REG_TIMEOUT) begin
      tap_timeout <= cfg_data[TOUT_WIDTH-1:0];
    end
  end

  for (genvar i = 0; i < BINDING_SLOTS; i++) begin : g_slot
    if (i < SLOT_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          slot[i] <= (i == 0) ? DEFAULT_SLOT0 : '0;
        end else if (cfg_write && cfg_index == IDX_WIDTH'(REG_SLOT_FIRST + i)) begin
          slot[i] <= cfg_data;
        end
      end
    end else begin : g_none
      assign slot[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed            <= 1'b0;
      latest_scancode  <= '0;
      pressed_scancode <= '0;
      press_seconds    <= '0;
      press_micros     <= '0;
    end else if (accept) begin
      if (is_scan) begin
        latest_scancode <= value;
        armed           <= 1'b1;
      end else if (key_act) begin
        armed <= 1'b0;
        if (is_press) begin
          pressed_scancode <= latest_scancode;
          press_seconds    <= evt.stamp_seconds;
          press_micros     <= evt.stamp_micros;
        end
      end
    end
  end

  // only d in {-1, 0, 1} needs the exact sum; d <= -2 is always negative
  always_comb begin
    dsec    = $signed({1'b0, evt.stamp_seconds}) - $signed({1'b0, press_seconds});
    udiff   = $signed({2'b00, evt.stamp_micros}) - $signed({2'b00, press_micros});
    d_gt1   = dsec > 33'sd1;
    d_le_m2 = dsec < -33'sd1;
    elapsed = (USEC_WIDTH+3)'(udiff);
    if (dsec == 33'sd1) begin
      elapsed = elapsed + (USEC_WIDTH+3)'(MICROS_PER_SEC);
    end else if (dsec == -33'sd1) begin
      elapsed = elapsed - (USEC_WIDTH+3)'(MICROS_PER_SEC);
    end
    in_time = (tap_timeout == '0) ||
              (!d_gt1 && (d_le_m2 ||
               ((TOUT_WIDTH+1)'(elapsed) <= $signed({1'b0, tap_timeout}))));
  end

  always_comb begin
    hit     = 1'b0;
    hit_cmd = '0;
    for (int i = BINDING_SLOTS - 1; i >= 0; i--) begin
      if (slot[i][15:0] != '0 && slot[i][15:0] == evt.event_code) begin
        hit              = 1'b1;
        hit_cmd.tap      = slot[i][31:16];
        hit_cmd.modifier = slot[i][47:32];
      end
    end
  end

  assign push = accept && !is_scan && key_act && !is_press &&
                (latest_scancode == pressed_scancode) && in_time && hit;
  assign push_cmd = hit_cmd;

  a_scan_arms: assert property (@(posedge clk) disable iff (rst)
    accept && is_scan |=> armed)
    else $error("scan report did not arm");
  a_push_disarms: assert property (@(posedge clk) disable iff (rst)
    push |=> !armed)
    else $error("tap left flag armed");
  a_press_no_push: assert property (@(posedge clk) disable iff (rst)
    push |-> evt.event_type == EV_KEY && evt.ready)
    else $error("tap from non key transaction");

endmodule

@@ rtl/core/drkt_queue.sv @@
module drkt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  drkt_pkg::tap_cmd_t push_cmd,
  output logic               not_full,
  input  logic               pop,
  output logic               q_valid,
  output drkt_pkg::tap_cmd_t q_cmd
);
  import drkt_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  tap_cmd_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;

  assign not_full = count < CNT_W'(QUEUE_DEPTH);
  assign q_valid  = count != '0;
  assign q_cmd    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> not_full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

@@ rtl/core/drkt_back.sv @@
module drkt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  drkt_pkg::tap_cmd_t q_cmd,
  output logic               pop,
  drkt_result_if.source      res
);
  import drkt_pkg::*;

  logic     busy;
  logic     busy_next;
  step_t    step;
  step_t    step_next;
  tap_cmd_t cmd;

  logic                  load;
  logic                  emit;
  logic                  last;
  logic                  o_type;
  logic [CODE_WIDTH-1:0] o_code;
  logic                  o_value;

  assign load = !res.valid || res.ready;
  assign emit = busy && load;
  assign last = step == STEP_SYNC;
  assign pop  = q_valid && (!busy || (emit && last));

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (pop) begin
      busy_next = 1'b1;
      step_next = (q_cmd.modifier != '0) ? STEP_MOD_DOWN : STEP_TAP_DOWN;
    end else if (emit) begin
      case (step)
        STEP_MOD_DOWN: step_next = STEP_TAP_DOWN;
        STEP_TAP_DOWN: step_next = STEP_TAP_UP;
        STEP_TAP_UP:   step_next = (cmd.modifier != '0) ? STEP_MOD_UP : STEP_SYNC;
        STEP_MOD_UP:   step_next = STEP_SYNC;
        default: begin
          step_next = STEP_SYNC;
          busy_next = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    case (step)
      STEP_MOD_DOWN: begin o_type = 1'b1; o_code = cmd.modifier; o_value = 1'b1; end
      STEP_TAP_DOWN: begin o_type = 1'b1; o_code = cmd.tap;      o_value = 1'b1; end
      STEP_TAP_UP:   begin o_type = 1'b1; o_code = cmd.tap;      o_value = 1'b0; end
      STEP_MOD_UP:   begin o_type = 1'b1; o_code = cmd.modifier; o_value = 1'b0; end
      default:       begin o_type = 1'b0; o_code = SYNC_CODE;    o_value = 1'b0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_SYNC;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.out_type    <= o_type;
      res.out_code    <= o_code;
      res.out_value   <= o_value;
      res.last_of_run <= last;
    end
  end

  a_sync_is_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.out_type |-> res.last_of_run && res.out_code == SYNC_CODE)
    else $error("sync transaction without end of run");
  a_skip_modifier: assert property (@(posedge clk) disable iff (rst)
    emit && step == STEP_TAP_UP && cmd.modifier == '0 && !pop |=> step == STEP_SYNC)
    else $error("modifier release without modifier");
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> res.valid)
    else $error("emitted transaction not presented");

endmodule

@@ rtl/core/dual_role_key_tap_detector_core.sv @@
// A tap's first result passes through the command queue, the back end's step register and the result register.
// Throughput: one input transaction per cycle while the two-entry command queue has room;
// a tap drains at one result per cycle while the receiver takes them, 3 results (no modifier) or 5 (with modifier),
// back to back from the command queue.
// The result register accepts a new result in the cycle the previous one is taken.
// Reset: synchronous, clears flags and the queue, restores timeout and bindings.
module dual_role_key_tap_detector_core #(
  parameter int unsigned BINDING_SLOTS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  drkt_pkg::cfg_index_t           cfg_index,
  input  logic [drkt_pkg::CFG_WIDTH-1:0] cfg_data,
  drkt_event_if.sink                     evt,
  drkt_result_if.source                  res
);
  import drkt_pkg::*;

  logic     push;
  tap_cmd_t push_cmd;
  logic     not_full;
  logic     pop;
  logic     q_valid;
  tap_cmd_t q_cmd;

  drkt_front #(
    .BINDING_SLOTS (BINDING_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt       (evt),
    .q_ready   (not_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  drkt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .not_full (not_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  drkt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .res     (res)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import drkt_pkg::*;

  localparam int unsigned SLOTS = 4;
  localparam logic [VALUE_WIDTH-1:0] VAL_RELEASE = '0;
  localparam logic OUT_SYNC = 1'b0;
  localparam logic OUT_KEY = 1'b1;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 88;
  localparam int REPORT_MAX = 10;
  localparam int OPENING_N = 26;

  typedef struct packed {
    logic [TYPE_WIDTH-1:0]  ev_type;
    logic [CODE_WIDTH-1:0]  code;
    logic [VALUE_WIDTH-1:0] value;
    logic [SEC_WIDTH-1:0]   sec;
    logic [USEC_WIDTH-1:0]  usec;
  } key_event_t;

  typedef struct packed {
    logic                  kind;
    logic [CODE_WIDTH-1:0] code;
    logic                  value;
    logic                  last;
  } key_out_t;

  typedef struct {
    logic [TYPE_WIDTH-1:0]  ev_type;
    logic [CODE_WIDTH-1:0]  code;
    logic [VALUE_WIDTH-1:0] value;
    logic [SEC_WIDTH-1:0]   sec;
    logic [USEC_WIDTH-1:0]  usec;
    int                     typed_n;
    logic [CODE_WIDTH-1:0]  tap;
    logic [CODE_WIDTH-1:0]  modifier;
  } opening_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  cfg_index_t cfg_index = REG_TIMEOUT;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  drkt_event_if evt_ch ();
  drkt_result_if res_ch ();

  dual_role_key_tap_detector_core #(.BINDING_SLOTS(SLOTS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .evt(evt_ch),
    .res(res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [TOUT_WIDTH-1:0] tap_window = DEFAULT_TIMEOUT;
  logic [CFG_WIDTH-1:0]  bindings [SLOTS];
  logic                  armed = 1'b0;
  logic [31:0]           latched_scan = '0;
  logic [31:0]           held_scan = '0;
  logic [SEC_WIDTH-1:0]  held_sec = '0;
  logic [USEC_WIDTH-1:0] held_usec = '0;
  logic [SEC_WIDTH-1:0]  clock_sec = 32'd1000;

  key_out_t tap_events_due [$];
  int fail_count = 0;
  int report_count = 0;
  int idle_run = 0;
  int fed_items = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int holdoff_left = 0;
  bit holdoff_req = 1'b0;

  int sender_pcts [4] = '{0, 54, 0, 13};
  int stall_pcts [4]  = '{0, 0, 54, 13};

  opening_row_t opening_rows [OPENING_N] = '{
    '{EV_KEY, 16'd42, VAL_PRESS, 32'd0, 20'd0, 0, 16'd0, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'h1E, 32'd5, 20'd0, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, VAL_PRESS, 32'd5, 20'd100, 0, 16'd0, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'h1E, 32'd5, 20'd150000, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, VAL_RELEASE, 32'd5, 20'd200100, 3, 16'd43, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'h1E, 32'd10, 20'd0, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, VAL_PRESS, 32'd10, 20'd999999, 0, 16'd0, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'h1E, 32'd11, 20'd0, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, VAL_REPEAT, 32'd11, 20'd100, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, VAL_RELEASE, 32'd11, 20'd200000, 0, 16'd0, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'hFFFF_FFFF, 32'd12, 20'd0, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, VAL_PRESS, 32'hFFFF_FFFF, 20'hFFFFF, 0, 16'd0, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, 32'h8000_0000, 32'd0, 20'd0, 3, 16'd43, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'h0, 32'd100, 20'd0, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, VAL_PRESS, 32'd100, 20'd0, 0, 16'd0, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'h0, 32'd101, 20'd0, 0, 16'd0, 16'd0},
    '{16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'd101, 20'd0, 0, 16'd0, 16'd0},
    '{EV_MSC, 16'd5, 32'h5A5A_5A5A, 32'd101, 20'd0, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, 32'hFFFF_FFFF, 32'd102, 20'd0, 0, 16'd0, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'h0, 32'd200, 20'd0, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, VAL_PRESS, 32'd200, 20'd0, 0, 16'd0, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'h1, 32'd200, 20'd10, 0, 16'd0, 16'd0},
    '{EV_KEY, 16'd42, VAL_RELEASE, 32'd200, 20'd20, 0, 16'd0, 16'd0},
    '{EV_MSC, MISC_SCAN_CODE, 32'h0, 32'd200, 20'd30, -1, 16'd0, 16'd0},
    '{EV_KEY, 16'd0, VAL_RELEASE, 32'd200, 20'd40, -1, 16'd0, 16'd0}
  };

  function automatic void apply_cfg(cfg_index_t idx, logic [CFG_WIDTH-1:0] data);
    int unsigned s;
    if (idx == REG_TIMEOUT) begin
      tap_window = data[TOUT_WIDTH-1:0];
    end else if (idx >= REG_SLOT_FIRST && idx < REG_SLOT_FIRST + SLOT_REGS) begin
      s = idx - REG_SLOT_FIRST;
      if (s < SLOTS) bindings[s] = data;
    end
  endfunction

  function automatic bit in_tap_window(logic [SEC_WIDTH-1:0] sec,
                                       logic [USEC_WIDTH-1:0] usec);
    longint gap;
    longint span;
    if (tap_window == '0) return 1'b1;
    gap = longint'(sec) - longint'(held_sec);
    if (gap > 1) return 1'b0;
    span = longint'(usec) - longint'(held_usec) + gap * MICROS_PER_SEC;
    return span <= longint'(tap_window);
  endfunction

  function automatic void tap_burst(logic [CODE_WIDTH-1:0] tap,
                                    logic [CODE_WIDTH-1:0] modifier,
                                    output key_out_t burst [$]);
    burst = {};
    if (modifier != '0) burst.push_back('{OUT_KEY, modifier, 1'b1, 1'b0});
    burst.push_back('{OUT_KEY, tap, 1'b1, 1'b0});
    burst.push_back('{OUT_KEY, tap, 1'b0, 1'b0});
    if (modifier != '0) burst.push_back('{OUT_KEY, modifier, 1'b0, 1'b0});
    burst.push_back('{OUT_SYNC, SYNC_CODE, 1'b0, 1'b1});
  endfunction

  // returns whether the event changed state or could tap
  function automatic bit track_event(key_event_t e, output key_out_t burst [$]);
    logic [CODE_WIDTH-1:0] trig;
    burst = {};
    if (e.ev_type == EV_MSC && e.code == MISC_SCAN_CODE) begin
      latched_scan = e.value;
      armed = 1'b1;
      return 1'b1;
    end
    if (e.ev_type != EV_KEY || !armed || e.value == VAL_REPEAT) return 1'b0;
    armed = 1'b0;
    if (e.value == VAL_PRESS) begin
      held_sec = e.sec;
      held_usec = e.usec;
      held_scan = latched_scan;
      return 1'b1;
    end
    if (latched_scan != held_scan || !in_tap_window(e.sec, e.usec)) return 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      trig = bindings[i][15:0];
      if (trig != '0 && trig == e.code) begin
        tap_burst(bindings[i][31:16], bindings[i][47:32], burst);
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  task automatic offer(key_event_t e, int typed_n = -1,
                       logic [CODE_WIDTH-1:0] tap = '0,
                       logic [CODE_WIDTH-1:0] modifier = '0);
    key_out_t burst [$];
    bit fed;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      evt_ch.valid = 1'b0;
      @(negedge clk);
    end
    evt_ch.valid = 1'b1;
    evt_ch.event_type = e.ev_type;
    evt_ch.event_code = e.code;
    evt_ch.event_value = e.value;
    evt_ch.stamp_seconds = e.sec;
    evt_ch.stamp_micros = e.usec;
    do @(posedge clk); while (!evt_ch.ready);
    fed = track_event(e, burst);
    if (typed_n == 0) burst = {};
    else if (typed_n > 0) tap_burst(tap, modifier, burst);
    foreach (burst[i]) tap_events_due.push_back(burst[i]);
    if (fed) fed_items++;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_WIDTH-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    apply_cfg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    evt_ch.valid = 1'b0;
    while (tap_events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_WIDTH-1:0] random_binding();
    logic [CODE_WIDTH-1:0] trig;
    logic [CODE_WIDTH-1:0] modifier;
    trig = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    modifier = $urandom_range(1) ? 16'($urandom) : 16'd0;
    return {modifier, 16'($urandom), trig};
  endfunction

  task automatic configure(int p);
    logic [CFG_WIDTH-1:0] slot_vals [SLOTS];
    logic [TOUT_WIDTH-1:0] window;
    foreach (slot_vals[i]) slot_vals[i] = random_binding();
    case (p)
      0: begin
        window = '1;
        slot_vals[0] = {16'd0, 16'd43, 16'd42};
        slot_vals[1] = {16'd29, 16'd31, 16'd30};
        slot_vals[2] = {16'd56, 16'd50, 16'd42};
        slot_vals[3] = {16'hFFFF, 16'hFFFF, 16'd0};
      end
      1: window = '0;
      2: window = 24'd1;
      default: begin
        window = 24'($urandom);
        slot_vals[1] = '1;
      end
    endcase
    write_reg(REG_TIMEOUT, CFG_WIDTH'(window));
    for (int i = 0; i < SLOTS; i++) write_reg(cfg_index_t'(REG_SLOT_FIRST + i), slot_vals[i]);
    if (p == 3) begin
      for (int i = REG_SLOT_FIRST + SLOT_REGS; i < 2 ** IDX_WIDTH; i++)
        write_reg(cfg_index_t'(i), '1);
    end
  endtask

  function automatic logic [CODE_WIDTH-1:0] pick_key();
    if ($urandom_range(99) < 75) return bindings[$urandom_range(SLOTS - 1)][15:0];
    return 16'($urandom);
  endfunction

  task automatic offer_noise();
    key_event_t e;
    e = '{16'($urandom), 16'($urandom), 32'($urandom), 32'($urandom), 20'($urandom)};
    case ($urandom_range(3))
      0: e.ev_type = EV_KEY;
      1: e.ev_type = EV_MSC;
      2: begin
        e.ev_type = EV_KEY;
        e.value = 32'($urandom_range(2));
      end
      default: ;
    endcase
    offer(e);
  endtask

  // scan, optional noise, press, scan (or scan and repeat), release with the release time spread around the window
  task automatic tap_attempt();
    logic [CODE_WIDTH-1:0] key;
    logic [31:0] scan;
    logic [31:0] rel_value;
    logic [SEC_WIDTH-1:0] sec0;
    logic [SEC_WIDTH-1:0] sec1;
    longint us0;
    longint us1;
    longint delta;
    longint scale;
    longint adv;
    key = pick_key();
    scan = 32'($urandom);
    if ($urandom_range(7) == 0) clock_sec = 32'($urandom);
    else clock_sec += $urandom_range(0, 4);
    sec0 = clock_sec;
    us0 = $urandom_range(999999);
    offer('{EV_MSC, MISC_SCAN_CODE, scan, sec0, 20'(us0)});
    if ($urandom_range(9) == 0) offer_noise();
    offer('{EV_KEY, key, VAL_PRESS, sec0, 20'(us0)});
    scale = (tap_window == '0) ? 200000 : longint'(tap_window);
    case ($urandom_range(5))
      0: delta = longint'($urandom) % (scale + 1);
      1: delta = scale;
      2: delta = scale + 1;
      3: delta = $urandom_range(0, 3000000);
      4: delta = -longint'($urandom_range(0, 2000000));
      default: delta = $urandom_range(0, 200);
    endcase
    us1 = us0 + delta;
    adv = us1 / MICROS_PER_SEC;
    us1 = us1 % MICROS_PER_SEC;
    if (us1 < 0) begin
      us1 += MICROS_PER_SEC;
      adv--;
    end
    sec1 = sec0 + 32'(adv);
    if ($urandom_range(9) == 0 && us1 < 48575) begin
      us1 += MICROS_PER_SEC;
      sec1 -= 1;
    end
    if ($urandom_range(4) == 0) begin
      offer('{EV_MSC, MISC_SCAN_CODE, scan, sec0, 20'(us0)});
      offer('{EV_KEY, key, VAL_REPEAT, sec0, 20'(us0)});
    end else begin
      offer('{EV_MSC, MISC_SCAN_CODE, ($urandom_range(9) == 0) ? 32'($urandom) : scan,
              sec1, 20'(us1)});
    end
    rel_value = ($urandom_range(9) == 0) ? (32'($urandom) | 32'h8) : VAL_RELEASE;
    offer('{EV_KEY, key, rel_value, sec1, 20'(us1)});
    clock_sec = sec1;
  endtask

  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      res_ch.ready = 1'b0;
      holdoff_left--;
    end else if (holdoff_req) begin
      holdoff_req = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
      res_ch.ready = 1'b0;
    end else begin
      res_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    key_out_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (tap_events_due.size() == 0) begin
        fail_count++;
        if (report_count < REPORT_MAX)
          $display("unexpected transaction: type %0d code %0d value %0d last %0d",
                   res_ch.out_type, res_ch.out_code, res_ch.out_value, res_ch.last_of_run);
        report_count++;
      end else begin
        want = tap_events_due.pop_front();
        if (res_ch.out_type !== want.kind || res_ch.out_code !== want.code ||
            res_ch.out_value !== want.value || res_ch.last_of_run !== want.last) begin
          fail_count++;
          if (report_count < REPORT_MAX)
            $display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.kind, want.code, want.value, want.last, res_ch.out_type,
                     res_ch.out_code, res_ch.out_value, res_ch.last_of_run);
          report_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) idle_run = 0;
    else idle_run++;
    if (idle_run >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAIL dual_role_key_tap_detector_core");
      $finish;
    end
  end

  initial begin
    opening_row_t r;
    int start;
    bit held_off;
    held_off = 1'b0;
    evt_ch.valid = 1'b0;
    evt_ch.event_type = '0;
    evt_ch.event_code = '0;
    evt_ch.event_value = '0;
    evt_ch.stamp_seconds = '0;
    evt_ch.stamp_micros = '0;
    res_ch.ready = 1'b0;
    foreach (bindings[i]) bindings[i] = '0;
    bindings[0] = DEFAULT_SLOT0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening_rows[i]) begin
      r = opening_rows[i];
      offer('{r.ev_type, r.code, r.value, r.sec, r.usec}, r.typed_n, r.tap, r.modifier);
    end

    for (int p = 0; p < 4; p++) begin
      settle();
      configure(p);
      sender_idle_pct = sender_pcts[p];
      stall_pct = stall_pcts[p];
      start = fed_items;
      while (fed_items - start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) offer_noise();
        else tap_attempt();
        // hold the receiver off while the sender keeps going
        if (p == 0 && !held_off && fed_items - start >= 30) begin
          holdoff_req = 1'b1;
          held_off = 1'b1;
        end
      end
    end

    settle();
    fail_count += tap_events_due.size();
    if (fail_count == 0) begin
      $display("PASS dual_role_key_tap_detector_core");
    end else begin
      $display("FAIL dual_role_key_tap_detector_core");
    end
    $finish;
  end

endmodule
